// ===== rtl/rwl_pkg.sv =====
// Package for the two-level readers-writers lock arbiter.
// Holds field widths, parameter defaults and the command, event and access codes.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package rwl_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_READERS_DEF = 64;

    localparam int CMD_W  = 3;
    localparam int ID_W   = 6;
    localparam int EV_W   = 3;
    localparam int KIND_W = 2;
    localparam int RA_W   = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ_REQ  = 3'd0,
        CMD_LOW_REQ   = 3'd1,
        CMD_HIGH_REQ  = 3'd2,
        CMD_READ_REL  = 3'd3,
        CMD_WRITE_REL = 3'd4
    } cmd_t;

    typedef enum logic [EV_W-1:0] {
        EV_GRANTED  = 3'd0,
        EV_QUEUED   = 3'd1,
        EV_REJECTED = 3'd2,
        EV_RELEASED = 3'd3,
        EV_REL_ERR  = 3'd4
    } event_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_READ = 2'd0,
        KIND_LOW  = 2'd1,
        KIND_HIGH = 2'd2
    } kind_t;

endpackage

// ===== rtl/rwl_req_if.sv =====
// Request channel of the lock arbiter: valid, ready and one command word.
// Depends on rwl_pkg for the field widths.
`timescale 1ns / 1ps

interface rwl_req_if;
    import rwl_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [ID_W-1:0]   requester_id;

    modport source (output valid, output command, output requester_id, input ready);
    modport sink   (input valid, input command, input requester_id, output ready);
endinterface

// ===== rtl/rwl_rsp_if.sv =====
// Result channel of the lock arbiter: valid, ready and one event word.
// Depends on rwl_pkg for the field widths.
`timescale 1ns / 1ps

interface rwl_rsp_if;
    import rwl_pkg::*;

    logic              valid;
    logic              ready;
    logic [EV_W-1:0]   event_res;
    logic [ID_W-1:0]   grant_id;
    logic [KIND_W-1:0] access_kind;
    logic [RA_W-1:0]   readers_active;
    logic              last;

    modport source (output valid, output event_res, output grant_id, output access_kind,
                    output readers_active, output last, input ready);
    modport sink   (input valid, input event_res, input grant_id, input access_kind,
                    input readers_active, input last, output ready);
endinterface

// ===== rtl/rw_lock_two_level_writer_priority.sv =====
// Top level of the readers-writers lock arbiter with high and low priority writers.
// Depends on rwl_pkg, rwl_req_if and rwl_rsp_if.
//
//   Channel | Direction | Word
//   req     | sink      | command, requester_id
//   rsp     | source    | event_res, grant_id, access_kind, readers_active, last
//
// A request or a release with nobody to wake gives one word.
// Each waiter woken on a release passes through S_READ, which reads its id from the
// queue memory's registered read port, and then S_EMIT, which emits the grant.
// Reset is asynchronous and clears all counts and pointers; queue entries are not cleared.
// A stalled result holds the block; no new word is taken until all results have left.
`timescale 1ns / 1ps

module rw_lock_two_level_writer_priority #(
    parameter int QUEUE_DEPTH = rwl_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_READERS = rwl_pkg::MAX_READERS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    rwl_req_if.sink     req,
    rwl_rsp_if.source   rsp
);
    import rwl_pkg::*;

    localparam int PW        = $clog2(QUEUE_DEPTH);
    localparam int CW        = $clog2(QUEUE_DEPTH + 1);
    localparam int RCW       = $clog2(MAX_READERS + 1);
    localparam int SLOTS     = 1 << PW;
    localparam int MEM_DEPTH = 3 * SLOTS;
    localparam int AW        = PW + 2;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [RCW-1:0]    reader_count_reg, reader_count_next;
    logic              writer_busy_reg, writer_busy_next;
    kind_t             writer_kind_reg, writer_kind_next;
    logic [PW-1:0]     head_reg [0:2];
    logic [PW-1:0]     head_next [0:2];
    logic [CW-1:0]     cnt_reg [0:2];
    logic [CW-1:0]     cnt_next [0:2];
    kind_t             pop_kind_reg, pop_kind_next;

    logic              out_valid_reg, out_valid_next;
    logic [EV_W-1:0]   out_event_reg, out_event_next;
    logic [ID_W-1:0]   out_id_reg, out_id_next;
    logic [KIND_W-1:0] out_kind_reg, out_kind_next;
    logic [RA_W-1:0]   out_ra_reg, out_ra_next;
    logic              out_last_reg, out_last_next;

    logic [ID_W-1:0]   mem [0:MEM_DEPTH-1];
    logic [ID_W-1:0]   rd_data_reg;
    logic              wr_en, rd_en;
    logic [AW-1:0]     wr_addr, rd_addr;

    logic              out_free, in_fire, load;
    kind_t             req_kind, sel_kind;
    logic [PW-1:0]     sel_head, head_inc, tail;
    logic [CW-1:0]     sel_cnt;
    logic [CW:0]       tail_sum;
    logic              busy, rc_nz, rc_full, hw_nz, lw_nz, rq_nz;
    logic              must_wait, q_full;
    logic [RCW-1:0]    rc_dec, rc_inc;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign in_fire   = req.valid && req.ready;

    assign req_kind = kind_t'(req.command[KIND_W-1:0]);
    assign sel_kind = (state_reg == S_IDLE) ? req_kind : pop_kind_reg;
    assign sel_head = head_reg[sel_kind];
    assign sel_cnt  = cnt_reg[sel_kind];
    assign tail_sum = (CW+1)'(sel_head) + (CW+1)'(sel_cnt);
    assign tail     = (tail_sum >= (CW+1)'(QUEUE_DEPTH))
                      ? PW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : PW'(tail_sum);
    assign head_inc = (sel_head == PW'(QUEUE_DEPTH - 1)) ? '0 : sel_head + PW'(1);
    assign q_full   = (sel_cnt == CW'(QUEUE_DEPTH));

    assign busy    = writer_busy_reg;
    assign rc_nz   = (reader_count_reg != '0);
    assign rc_full = (reader_count_reg >= RCW'(MAX_READERS));
    assign hw_nz   = (cnt_reg[KIND_HIGH] != '0);
    assign lw_nz   = (cnt_reg[KIND_LOW] != '0);
    assign rq_nz   = (cnt_reg[KIND_READ] != '0);
    assign rc_dec  = reader_count_reg - RCW'(1);
    assign rc_inc  = reader_count_reg + RCW'(1);

    always_comb
    begin
        unique case (req.command)
            CMD_READ_REQ: must_wait = busy || hw_nz || lw_nz || rq_nz || rc_full;
            CMD_LOW_REQ:  must_wait = busy || rc_nz || hw_nz || lw_nz;
            default:      must_wait = busy || rc_nz || hw_nz;
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        reader_count_next = reader_count_reg;
        writer_busy_next  = writer_busy_reg;
        writer_kind_next  = writer_kind_reg;
        pop_kind_next     = pop_kind_reg;
        for (int k = 0; k < 3; k++)
        begin
            head_next[k] = head_reg[k];
            cnt_next[k]  = cnt_reg[k];
        end
        load           = 1'b0;
        out_event_next = out_event_reg;
        out_id_next    = out_id_reg;
        out_kind_next  = out_kind_reg;
        out_ra_next    = out_ra_reg;
        out_last_next  = out_last_reg;
        wr_en          = 1'b0;
        wr_addr        = {sel_kind, tail};
        rd_en          = 1'b0;
        rd_addr        = {pop_kind_reg, head_reg[pop_kind_reg]};

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    out_id_next   = req.requester_id;
                    out_last_next = 1'b1;
                    out_ra_next   = RA_W'(reader_count_reg);
                    case (req.command)
                        CMD_READ_REQ, CMD_LOW_REQ, CMD_HIGH_REQ:
                        begin
                            load          = 1'b1;
                            out_kind_next = req_kind;
                            if (!must_wait)
                            begin
                                out_event_next = EV_GRANTED;
                                if (req_kind == KIND_READ)
                                begin
                                    reader_count_next = rc_inc;
                                    out_ra_next       = RA_W'(rc_inc);
                                end
                                else
                                begin
                                    writer_busy_next = 1'b1;
                                    writer_kind_next = req_kind;
                                end
                            end
                            else if (!q_full)
                            begin
                                out_event_next     = EV_QUEUED;
                                wr_en              = 1'b1;
                                cnt_next[sel_kind] = sel_cnt + CW'(1);
                            end
                            else
                            begin
                                out_event_next = EV_REJECTED;
                            end
                        end
                        CMD_READ_REL:
                        begin
                            load          = 1'b1;
                            out_kind_next = KIND_READ;
                            if (!rc_nz)
                            begin
                                out_event_next = EV_REL_ERR;
                            end
                            else
                            begin
                                out_event_next    = EV_RELEASED;
                                reader_count_next = rc_dec;
                                out_ra_next       = RA_W'(rc_dec);
                                if (rc_dec == '0 && (hw_nz || lw_nz || rq_nz))
                                begin
                                    out_last_next = 1'b0;
                                    state_next    = S_READ;
                                    pop_kind_next = hw_nz ? KIND_HIGH
                                                  : (lw_nz ? KIND_LOW : KIND_READ);
                                end
                                else if (!hw_nz && !lw_nz && rq_nz)
                                begin
                                    out_last_next = 1'b0;
                                    state_next    = S_READ;
                                    pop_kind_next = KIND_READ;
                                end
                            end
                        end
                        CMD_WRITE_REL:
                        begin
                            load = 1'b1;
                            if (!busy)
                            begin
                                out_event_next = EV_REL_ERR;
                                out_kind_next  = KIND_LOW;
                            end
                            else
                            begin
                                out_event_next   = EV_RELEASED;
                                out_kind_next    = writer_kind_reg;
                                writer_busy_next = 1'b0;
                                if (hw_nz || lw_nz || rq_nz)
                                begin
                                    out_last_next = 1'b0;
                                    state_next    = S_READ;
                                    pop_kind_next = hw_nz ? KIND_HIGH
                                                  : (lw_nz ? KIND_LOW : KIND_READ);
                                end
                            end
                        end
                        default:
                        begin
                            load = 1'b0;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                rd_en      = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    load                = 1'b1;
                    out_event_next      = EV_GRANTED;
                    out_id_next         = rd_data_reg;
                    out_kind_next       = pop_kind_reg;
                    head_next[sel_kind] = head_inc;
                    cnt_next[sel_kind]  = sel_cnt - CW'(1);
                    if (pop_kind_reg == KIND_READ)
                    begin
                        reader_count_next = rc_inc;
                        out_ra_next       = RA_W'(rc_inc);
                        if ((sel_cnt != CW'(1)) && (rc_inc < RCW'(MAX_READERS)))
                        begin
                            out_last_next = 1'b0;
                            state_next    = S_READ;
                        end
                        else
                        begin
                            out_last_next = 1'b1;
                            state_next    = S_IDLE;
                        end
                    end
                    else
                    begin
                        writer_busy_next = 1'b1;
                        writer_kind_next = pop_kind_reg;
                        out_ra_next      = RA_W'(reader_count_reg);
                        out_last_next    = 1'b1;
                        state_next       = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            reader_count_reg <= '0;
            writer_busy_reg  <= 1'b0;
            writer_kind_reg  <= KIND_LOW;
            pop_kind_reg     <= KIND_READ;
            out_valid_reg    <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                head_reg[k] <= '0;
                cnt_reg[k]  <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            reader_count_reg <= reader_count_next;
            writer_busy_reg  <= writer_busy_next;
            writer_kind_reg  <= writer_kind_next;
            pop_kind_reg     <= pop_kind_next;
            out_valid_reg    <= out_valid_next;
            for (int k = 0; k < 3; k++)
            begin
                head_reg[k] <= head_next[k];
                cnt_reg[k]  <= cnt_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_event_reg <= out_event_next;
        out_id_reg    <= out_id_next;
        out_kind_reg  <= out_kind_next;
        out_ra_reg    <= out_ra_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= req.requester_id;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.event_res      = out_event_reg;
    assign rsp.grant_id       = out_id_reg;
    assign rsp.access_kind    = out_kind_reg;
    assign rsp.readers_active = out_ra_reg;
    assign rsp.last           = out_last_reg;

endmodule

// ===== rtl/rwl_checker.sv =====
// Port checker for the lock arbiter, attached to the top level by a bind statement.
// Depends on rwl_pkg and on the top level rw_lock_two_level_writer_priority.
`timescale 1ns / 1ps

module rwl_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_ready,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic [rwl_pkg::EV_W-1:0]   event_res,
    input logic [rwl_pkg::ID_W-1:0]   grant_id,
    input logic [rwl_pkg::KIND_W-1:0] access_kind,
    input logic [rwl_pkg::RA_W-1:0]   readers_active,
    input logic                       last
);
    import rwl_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(event_res) && $stable(grant_id)
            && $stable(access_kind) && $stable(readers_active) && $stable(last))
        else $error("Result word changed while stalled.");

    a_wait_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (event_res == EV_QUEUED || event_res == EV_REJECTED) |-> last)
        else $error("A queued or rejected request did not end its sequence.");

    a_write_rel_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && event_res == EV_RELEASED && access_kind != KIND_READ
            |-> readers_active == '0)
        else $error("Readers were active while a writer held the lock.");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |-> !rsp_valid || rsp_ready)
        else $error("A request was taken while a result was stalled.");

endmodule

bind rw_lock_two_level_writer_priority rwl_checker u_rwl_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .event_res      (rsp.event_res),
    .grant_id       (rsp.grant_id),
    .access_kind    (rsp.access_kind),
    .readers_active (rsp.readers_active),
    .last           (rsp.last)
);
